[rtl/pslb_pkg.sv]
// shared types and constants for the per-source leaky bucket limiter
package pslb_pkg;

  localparam logic [1:0] VERDICT_PASS  = 2'd0;
  localparam logic [1:0] VERDICT_DROP  = 2'd1;
  localparam logic [1:0] VERDICT_ERROR = 2'd2;

  localparam logic CFG_LEAK_RATE   = 1'b0;
  localparam logic CFG_LEVEL_LIMIT = 1'b1;

  typedef struct packed {
    logic        empty_src;
    logic [31:0] address;
    logic [31:0] now;
    logic [31:0] hash;
  } req_t;

  // golden-ratio hash folded down; low bits give the probe start
  function automatic logic [31:0] probe_hash(input logic [31:0] addr);
    logic [31:0] h;
    h = addr * 32'd2654435761;
    return h ^ (h >> 16);
  endfunction

endpackage

[rtl/pslb_front.sv]
// front end: takes requests, hashes the address and flags empty sources
module pslb_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 valid,
  output logic                 ready,
  input  logic [31:0]          source_address,
  input  logic [31:0]          now_seconds,
  output logic                 q_valid,
  input  logic                 q_ready,
  output pslb_pkg::req_t       q_req
);

  // the multiply is registered; a stage holds one request
  logic full;

  assign ready   = !full || q_ready;
  assign q_valid = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (ready) begin
      full <= valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && valid) begin
      q_req.empty_src <= (source_address == 32'd0);
      q_req.address   <= source_address;
      q_req.now       <= now_seconds;
      q_req.hash      <= pslb_pkg::probe_hash(source_address);
    end
  end

endmodule

[rtl/pslb_queue.sv]
// two-entry request queue between front and back
module pslb_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  pslb_pkg::req_t in_req,
  output logic           out_valid,
  input  logic           out_ready,
  output pslb_pkg::req_t out_req
);

  pslb_pkg::req_t mem [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_req   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mem[wr_ptr] <= in_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (in_valid && in_ready) wr_ptr <= !wr_ptr;
      if (out_valid && out_ready) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, in_valid && in_ready} - {1'b0, out_valid && out_ready};
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |-> !in_ready) else $error("queue overflow");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("queue count out of range");
  a_empty_stays: assert property (@(posedge clk) disable iff (rst)
    count == 2'd0 && !in_valid |=> count == 2'd0) else $error("queue count moved");
`endif

endmodule

[rtl/pslb_back.sv]
// back end: probes the bucket table, drains, updates and issues the verdict
module pslb_back #(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_ready,
  input  pslb_pkg::req_t q_req,
  input  logic [15:0]    leak_rate,
  input  logic [15:0]    level_limit,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     verdict,
  output logic [15:0]    bucket_level
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = IW + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  // valid bits in flip-flops, bucket data in a memory
  logic [TABLE_ENTRIES-1:0] used;
  logic [79:0] mem [TABLE_ENTRIES];
  logic [79:0] rd_data;

  logic [IW-1:0] idx;
  logic [CW-1:0] probes;
  logic [31:0]   address;
  logic [31:0]   now;
  logic          hit_used;
  logic [15:0]   level;
  logic [31:0]   last_time;
  logic [47:0]   drain;
  logic          elapsed_pos;

  logic [IW-1:0] hash_lo;
  logic [IW-1:0] start_idx;
  logic [IW-1:0] idx_inc;
  logic [16:0]   lvl_inc;
  logic [15:0]   lvl_drained;

  assign q_ready = (state == S_IDLE);

  always_comb begin
    // low hash bits folded once into the table range
    hash_lo = q_req.hash[IW-1:0];
    if ({1'b0, hash_lo} >= CW'(TABLE_ENTRIES)) begin
      start_idx = IW'({1'b0, hash_lo} - CW'(TABLE_ENTRIES));
    end else begin
      start_idx = hash_lo;
    end
    if ({1'b0, idx} == CW'(TABLE_ENTRIES - 1)) idx_inc = '0;
    else idx_inc = idx + 1'b1;
    lvl_drained = (drain >= {32'd0, level}) ? 16'd0 : level - drain[15:0];
    lvl_inc = (lvl_drained == 16'hFFFF) ? 17'h0FFFF : {1'b0, lvl_drained} + 17'd1;
  end

  always_ff @(posedge clk) begin
    rd_data  <= mem[idx];
    hit_used <= used[idx];
    if (state == S_WRITE) begin
      mem[idx] <= {address, lvl_inc[15:0], elapsed_pos ? now : last_time};
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (q_valid) state_next = q_req.empty_src ? S_OUT : S_READ;
      S_READ: state_next = S_CHECK;
      S_CHECK: begin
        if (!hit_used || rd_data[79:48] == address) state_next = S_MUL;
        else if (probes == CW'(TABLE_ENTRIES - 1)) state_next = S_OUT;
        else state_next = S_READ;
      end
      S_MUL:   state_next = S_WRITE;
      S_WRITE: state_next = S_OUT;
      S_OUT:   if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_WRITE) used[idx] <= 1'b1;
      if (state_next == S_OUT && state != S_OUT) out_valid <= 1'b1;
      else if (state == S_OUT && out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        idx     <= start_idx;
        probes  <= '0;
        address <= q_req.address;
        now     <= q_req.now;
        verdict <= pslb_pkg::VERDICT_ERROR;
        bucket_level <= 16'd0;
      end
      S_CHECK: begin
        if (!hit_used) begin
          level     <= 16'd0;
          last_time <= now;
        end else begin
          level     <= rd_data[47:32];
          last_time <= rd_data[31:0];
        end
        if (hit_used && rd_data[79:48] != address) begin
          idx    <= idx_inc;
          probes <= probes + 1'b1;
        end
      end
      S_MUL: begin
        elapsed_pos <= now > last_time;
        drain <= (now > last_time) ? 48'(now - last_time) * 48'(leak_rate) : 48'd0;
      end
      S_WRITE: begin
        bucket_level <= lvl_inc[15:0];
        verdict <= (lvl_inc[15:0] > level_limit) ? pslb_pkg::VERDICT_DROP
                                                 : pslb_pkg::VERDICT_PASS;
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_out_in_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_OUT) else $error("result shown outside output state");
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict == pslb_pkg::VERDICT_ERROR |-> bucket_level == 16'd0)
    else $error("error result with nonzero level");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(verdict))
    else $error("result dropped while stalled");
`endif

endmodule

[rtl/per_source_leaky_bucket_limiter.sv]
// Per-source leaky bucket limiter top level. A request passes the front
// register and the queue; the back end then does a memory read and a compare
// per slot of the linear probe, then the drain multiply, the write-back and
// the output state. A source found at its home slot takes one probe, a full
// walk every slot, and an empty source skips the table. The back end works
// on one request at a time and sets the rate; a stalled result holds it in
// place. A short queue lets new requests be hashed while the back end works.
module per_source_leaky_bucket_limiter #(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        ready,
  input  logic [31:0] source_address,
  input  logic [31:0] now_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  verdict,
  output logic [15:0] bucket_level,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] leak_rate;
  logic [15:0] level_limit;
  logic f_valid, f_ready, b_valid, b_ready;
  pslb_pkg::req_t f_req, b_req;

  always_ff @(posedge clk) begin
    if (rst) begin
      leak_rate   <= 16'd1;
      level_limit <= 16'd10;
    end else if (cfg_we) begin
      if (cfg_index == pslb_pkg::CFG_LEAK_RATE) leak_rate <= cfg_data;
      else level_limit <= cfg_data;
    end
  end

  pslb_front u_front (
    .clk, .rst, .valid, .ready, .source_address, .now_seconds,
    .q_valid(f_valid), .q_ready(f_ready), .q_req(f_req)
  );

  pslb_queue u_queue (
    .clk, .rst, .in_valid(f_valid), .in_ready(f_ready), .in_req(f_req),
    .out_valid(b_valid), .out_ready(b_ready), .out_req(b_req)
  );

  pslb_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
    .clk, .rst, .q_valid(b_valid), .q_ready(b_ready), .q_req(b_req),
    .leak_rate, .level_limit, .out_valid, .out_ready, .verdict, .bucket_level
  );

endmodule
